@@ sv/lbtb_pkg.sv @@
// ----------------------------------------------------------------------------
// Lifetime bucket timer bank package
// Shared codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lbtb_pkg;

    typedef enum logic [1:0] {
        F_ADD  = 2'd0,
        F_DEL  = 2'd1,
        F_TICK = 2'd2,
        F_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        K_ADDED     = 3'd0,
        K_PRESENT   = 3'd1,
        K_NO_BUCKET = 3'd2,
        K_NO_SLOT   = 3'd3,
        K_DELETED   = 3'd4,
        K_FIRED     = 3'd5,
        K_NONE_EXP  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        M_ADD  = 2'd0,
        M_DEL  = 2'd1,
        M_CAND = 2'd2,
        M_SEL  = 2'd3
    } t_mode;

    localparam int MAX_FIRE = 32;
    localparam int NFW      = $clog2(MAX_FIRE + 1);

    typedef struct packed {
        logic  capture;
        logic  bstep;
        logic  sinit;
        logic  sstep;
        t_mode mode;
        logic  commit;
        logic  fire;
        logic  flush;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  bdone;
        logic  sdone;
        logic  more;
    } t_stat;

endpackage

@@ sv/lbtb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Lifetime bucket timer bank controller
// Sequences bucket scan, slot scans and commit/fire steps for each item.
// ----------------------------------------------------------------------------
module lbtb_ctrl
    import lbtb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_func,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       busy
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_BSCAN  = 9'b000000010,
        S_SSCAN  = 9'b000000100,
        S_COMMIT = 9'b000001000,
        S_CAND   = 9'b000010000,
        S_SELI   = 9'b000100000,
        S_SEL    = 9'b001000000,
        S_FIRE   = 9'b010000000,
        S_FLUSH  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.sinit   = 1'b1;
                    unique case (t_func'(i_func))
                        F_ADD, F_DEL: n_state = S_BSCAN;
                        F_TICK:       n_state = S_CAND;
                        F_NONE:       n_state = S_IDLE;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_BSCAN: begin
                o_cmd.bstep = 1'b1;
                if (i_stat.bdone) n_state = S_SSCAN;
            end
            S_SSCAN: begin
                o_cmd.sstep = 1'b1;
                o_cmd.mode  = (i_stat.func == F_ADD) ? M_ADD : M_DEL;
                if (i_stat.sdone) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            S_CAND: begin
                o_cmd.sstep = 1'b1;
                o_cmd.mode  = M_CAND;
                if (i_stat.sdone) n_state = S_SELI;
            end
            S_SELI: begin
                o_cmd.sinit = 1'b1;
                n_state     = S_SEL;
            end
            S_SEL: begin
                o_cmd.sstep = 1'b1;
                o_cmd.mode  = M_SEL;
                if (i_stat.sdone) n_state = S_FIRE;
            end
            S_FIRE: begin
                o_cmd.fire = 1'b1;
                n_state    = i_stat.more ? S_SELI : S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ sv/lbtb_dp.sv @@
// ----------------------------------------------------------------------------
// Lifetime bucket timer bank datapath
// Bucket table, slot memories, scan pipeline, best-expiry search, results.
// ----------------------------------------------------------------------------
module lbtb_dp
    import lbtb_pkg::*;
#(
    parameter int NUM_BUCKETS = 32,
    parameter int NUM_SLOTS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_lifetime,
    input  logic        i_repeat_req,
    input  logic [3:0]  i_queue_id,
    input  logic [31:0] i_handler_tag,
    input  logic [31:0] i_arg_tag,
    output t_stat       o_stat,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_fired_queue,
    output logic [31:0] o_fired_handler,
    output logic [31:0] o_fired_arg,
    output logic [5:0]  o_removed_count,
    output logic        o_last
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // input item
    t_func       r_func;
    logic [15:0] r_lt;
    logic        r_rep;
    logic [3:0]  r_q;
    logic [31:0] r_h;
    logic [31:0] r_a;

    // bucket table
    logic [15:0]   r_blt  [NUM_BUCKETS];
    logic [CW-1:0] r_bcnt [NUM_BUCKETS];
    logic [BW-1:0] r_bidx;
    logic [BW-1:0] r_bm;
    logic          r_bm_f;
    logic [BW-1:0] r_be;
    logic          r_be_f;

    // slot storage
    logic [BW-1:0] m_bucket [NUM_SLOTS];
    logic          m_rep    [NUM_SLOTS];
    logic [3:0]    m_q      [NUM_SLOTS];
    logic [31:0]   m_h      [NUM_SLOTS];
    logic [31:0]   m_a      [NUM_SLOTS];
    logic [31:0]   m_exp    [NUM_SLOTS];
    logic [15:0]   m_stamp  [NUM_SLOTS];
    logic [BW-1:0] r_rd_bucket;
    logic          r_rd_rep;
    logic [3:0]    r_rd_q;
    logic [31:0]   r_rd_h;
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_exp;
    logic [15:0]   r_rd_stamp;
    logic          r_valid [NUM_SLOTS];
    logic          r_cand  [NUM_SLOTS];

    // scan pipeline
    logic [SW-1:0] r_sidx;
    logic          r_send;
    logic          r_ev;
    logic [SW-1:0] r_eidx;
    logic          r_dup;
    logic [SW-1:0] r_free;
    logic          r_free_f;
    logic [CW-1:0] r_rem;

    // time
    logic [31:0] r_now;
    logic [15:0] r_stc;
    logic [15:0] r_snap;

    // best candidate and pending fire
    logic           r_bst_f;
    logic [SW-1:0]  r_bst_idx;
    logic [BW-1:0]  r_bst_b;
    logic [31:0]    r_bst_ax;
    logic [15:0]    r_bst_sa;
    logic           r_bst_rep;
    logic [3:0]     r_bst_q;
    logic [31:0]    r_bst_h;
    logic [31:0]    r_bst_a;
    logic           r_pnd_f;
    logic [3:0]     r_pnd_q;
    logic [31:0]    r_pnd_h;
    logic [31:0]    r_pnd_a;
    logic [NFW-1:0] r_nf;

    // result
    logic        r_stb;
    t_kind       r_kind;
    logic [3:0]  r_oq;
    logic [31:0] r_oh;
    logic [31:0] r_oa;
    logic [5:0]  r_orem;
    logic        r_olast;

    logic [BW-1:0] w_bix;
    logic [15:0]   w_blt;
    logic [CW-1:0] w_bcnt;
    logic          w_val_e;
    logic          w_cand_e;
    logic [31:0]   w_ax;
    logic [15:0]   w_sa;
    logic          w_same;
    logic          w_better;
    logic          w_eval;
    t_kind         w_kind_add;
    logic          w_add_we;
    logic          w_rearm;
    logic [SW-1:0] w_waddr;

    always_comb begin
        priority if (i_cmd.commit) begin
            w_bix = (r_func == F_ADD && !r_bm_f) ? r_be : r_bm;
        end else if (i_cmd.fire) begin
            w_bix = r_bst_b;
        end else begin
            w_bix = r_bidx;
        end
    end

    assign w_blt    = r_blt[w_bix];
    assign w_bcnt   = r_bcnt[w_bix];
    assign w_val_e  = r_valid[r_eidx];
    assign w_cand_e = r_cand[r_eidx];
    assign w_ax     = r_now - r_rd_exp;
    assign w_sa     = r_snap - r_rd_stamp;
    assign w_same   = (r_rd_q == r_q) && (r_rd_h == r_h) && (r_rd_a == r_a);
    assign w_eval   = i_cmd.sstep && r_ev;
    assign w_better = !r_bst_f || (r_rd_bucket < r_bst_b) ||
                      ((r_rd_bucket == r_bst_b) &&
                       ((w_ax > r_bst_ax) || ((w_ax == r_bst_ax) && (w_sa > r_bst_sa))));

    always_comb begin
        priority if (r_rep && r_bm_f && r_dup) begin
            w_kind_add = K_PRESENT;
        end else if (!r_bm_f && !r_be_f) begin
            w_kind_add = K_NO_BUCKET;
        end else if (!r_free_f) begin
            w_kind_add = K_NO_SLOT;
        end else begin
            w_kind_add = K_ADDED;
        end
    end

    assign w_add_we = i_cmd.commit && (r_func == F_ADD) && (w_kind_add == K_ADDED);
    assign w_rearm  = i_cmd.fire && r_bst_f && r_bst_rep;
    assign w_waddr  = i_cmd.fire ? r_bst_idx : r_free;

    // slot memories
    always_ff @(posedge i_clk) begin
        r_rd_bucket <= m_bucket[r_sidx];
        r_rd_rep    <= m_rep[r_sidx];
        r_rd_q      <= m_q[r_sidx];
        r_rd_h      <= m_h[r_sidx];
        r_rd_a      <= m_a[r_sidx];
        r_rd_exp    <= m_exp[r_sidx];
        r_rd_stamp  <= m_stamp[r_sidx];
        if (w_add_we) begin
            m_bucket[w_waddr] <= w_bix;
            m_rep[w_waddr]    <= r_rep;
            m_q[w_waddr]      <= r_q;
            m_h[w_waddr]      <= r_h;
            m_a[w_waddr]      <= r_a;
            m_exp[w_waddr]    <= r_now + {16'd0, r_lt};
            m_stamp[w_waddr]  <= r_stc;
        end else if (w_rearm) begin
            m_exp[w_waddr]    <= r_now + {16'd0, w_blt};
            m_stamp[w_waddr]  <= r_stc;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_blt[i]  <= '0;
                r_bcnt[i] <= '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_cand[i]  <= 1'b0;
            end
            r_func    <= F_NONE;
            r_bidx    <= '0;
            r_bm      <= '0;
            r_bm_f    <= 1'b0;
            r_be      <= '0;
            r_be_f    <= 1'b0;
            r_sidx    <= '0;
            r_send    <= 1'b0;
            r_ev      <= 1'b0;
            r_eidx    <= '0;
            r_dup     <= 1'b0;
            r_free    <= '0;
            r_free_f  <= 1'b0;
            r_rem     <= '0;
            r_now     <= '0;
            r_stc     <= '0;
            r_snap    <= '0;
            r_bst_f   <= 1'b0;
            r_bst_idx <= '0;
            r_bst_b   <= '0;
            r_bst_ax  <= '0;
            r_bst_sa  <= '0;
            r_bst_rep <= 1'b0;
            r_pnd_f   <= 1'b0;
            r_nf      <= '0;
            r_stb     <= 1'b0;
        end else begin
            r_stb <= 1'b0;
            if (i_cmd.capture) begin
                r_func <= t_func'(i_func);
                r_bidx <= '0;
                r_bm_f <= 1'b0;
                r_be_f <= 1'b0;
                if (t_func'(i_func) == F_TICK) begin
                    r_now   <= r_now + 32'd1;
                    r_snap  <= r_stc;
                    r_nf    <= '0;
                    r_pnd_f <= 1'b0;
                end
            end
            if (i_cmd.bstep) begin
                if (!r_bm_f && (w_blt == r_lt)) begin
                    r_bm_f <= 1'b1;
                    r_bm   <= r_bidx;
                end
                if (!r_be_f && (w_bcnt == '0)) begin
                    r_be_f <= 1'b1;
                    r_be   <= r_bidx;
                end
                if (r_bidx != BW'(NUM_BUCKETS - 1)) r_bidx <= r_bidx + 1'b1;
            end
            if (i_cmd.sinit) begin
                r_sidx   <= '0;
                r_send   <= 1'b0;
                r_ev     <= 1'b0;
                r_dup    <= 1'b0;
                r_free_f <= 1'b0;
                r_rem    <= '0;
                r_bst_f  <= 1'b0;
            end
            if (i_cmd.sstep) begin
                r_ev   <= !r_send;
                r_eidx <= r_sidx;
                if (r_sidx == SW'(NUM_SLOTS - 1)) begin
                    r_send <= 1'b1;
                end else begin
                    r_sidx <= r_sidx + 1'b1;
                end
            end
            if (w_eval) begin
                unique case (i_cmd.mode)
                    M_ADD: begin
                        if (!r_free_f && !w_val_e) begin
                            r_free_f <= 1'b1;
                            r_free   <= r_eidx;
                        end
                        if (w_val_e && (r_rd_bucket == r_bm) && r_rd_rep && w_same) begin
                            r_dup <= 1'b1;
                        end
                    end
                    M_DEL: begin
                        if (r_bm_f && w_val_e && (r_rd_bucket == r_bm) &&
                            (r_rd_rep == r_rep) && w_same) begin
                            r_valid[r_eidx] <= 1'b0;
                            r_rem           <= r_rem + 1'b1;
                        end
                    end
                    M_CAND: begin
                        r_cand[r_eidx] <= w_val_e && !w_ax[31];
                    end
                    M_SEL: begin
                        if (w_cand_e && w_better) begin
                            r_bst_f   <= 1'b1;
                            r_bst_idx <= r_eidx;
                            r_bst_b   <= r_rd_bucket;
                            r_bst_ax  <= w_ax;
                            r_bst_sa  <= w_sa;
                            r_bst_rep <= r_rd_rep;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_stb <= 1'b1;
                if (r_func == F_ADD) begin
                    if (w_kind_add == K_ADDED) begin
                        r_valid[r_free] <= 1'b1;
                        if (!r_bm_f) r_blt[w_bix] <= r_lt;
                        r_bcnt[w_bix] <= w_bcnt + 1'b1;
                        r_stc         <= r_stc + 16'd1;
                    end
                end else if (r_bm_f) begin
                    r_bcnt[w_bix] <= (w_bcnt >= r_rem) ? (w_bcnt - r_rem) : '0;
                end
            end
            if (i_cmd.fire && r_bst_f) begin
                r_cand[r_bst_idx] <= 1'b0;
                if (r_pnd_f) r_stb <= 1'b1;
                r_pnd_f <= 1'b1;
                r_nf    <= r_nf + 1'b1;
                if (r_bst_rep) begin
                    r_stc <= r_stc + 16'd1;
                end else begin
                    r_valid[r_bst_idx] <= 1'b0;
                    if (w_bcnt != '0) r_bcnt[w_bix] <= w_bcnt - 1'b1;
                end
            end
            if (i_cmd.flush) r_stb <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lt  <= i_lifetime;
            r_rep <= i_repeat_req;
            r_q   <= i_queue_id;
            r_h   <= i_handler_tag;
            r_a   <= i_arg_tag;
        end
        if (w_eval && (i_cmd.mode == M_SEL) && w_cand_e && w_better) begin
            r_bst_q <= r_rd_q;
            r_bst_h <= r_rd_h;
            r_bst_a <= r_rd_a;
        end
        if (i_cmd.commit) begin
            r_kind  <= (r_func == F_ADD) ? w_kind_add : K_DELETED;
            r_oq    <= '0;
            r_oh    <= '0;
            r_oa    <= '0;
            r_orem  <= (r_func == F_ADD) ? 6'd0 : 6'(r_rem);
            r_olast <= 1'b1;
        end
        if (i_cmd.fire && r_bst_f) begin
            r_kind  <= K_FIRED;
            r_oq    <= r_pnd_q;
            r_oh    <= r_pnd_h;
            r_oa    <= r_pnd_a;
            r_orem  <= '0;
            r_olast <= 1'b0;
            r_pnd_q <= r_bst_q;
            r_pnd_h <= r_bst_h;
            r_pnd_a <= r_bst_a;
        end
        if (i_cmd.flush) begin
            r_kind  <= r_pnd_f ? K_FIRED : K_NONE_EXP;
            r_oq    <= r_pnd_f ? r_pnd_q : 4'd0;
            r_oh    <= r_pnd_f ? r_pnd_h : 32'd0;
            r_oa    <= r_pnd_f ? r_pnd_a : 32'd0;
            r_orem  <= '0;
            r_olast <= 1'b1;
        end
    end

    assign o_stat.func  = r_func;
    assign o_stat.bdone = (r_bidx == BW'(NUM_BUCKETS - 1));
    assign o_stat.sdone = r_ev && (r_eidx == SW'(NUM_SLOTS - 1));
    assign o_stat.more  = r_bst_f && (r_nf != NFW'(MAX_FIRE - 1));

    assign o_strobe        = r_stb;
    assign o_kind          = r_kind;
    assign o_fired_queue   = r_oq;
    assign o_fired_handler = r_oh;
    assign o_fired_arg     = r_oa;
    assign o_removed_count = r_orem;
    assign o_last          = r_olast;

endmodule

@@ sv/lifetime_bucket_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// Lifetime bucket timer bank
// One-shot and repeating timers grouped into lifetime buckets.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   command | start & !busy         | i_func i_lifetime i_repeat_req i_queue_id
//           |                       | i_handler_tag i_arg_tag
//   result  | o_strobe (one cycle)  | o_kind o_fired_queue o_fired_handler
//           |                       | o_fired_arg o_removed_count o_last
//
// Add/delete: a bucket scan, then a slot scan, then a commit.
// Tick: an expiry pass over the slots, then a best-expiry search and a fire
// step per fired timer, and a final flush; a search that finds nothing ends it.
// Synchronous active-low reset clears all timers, buckets and counters.
// Results cannot be stalled; busy stays high until the item's last transfer.
// ----------------------------------------------------------------------------
module lifetime_bucket_timer_bank_top
    import lbtb_pkg::*;
#(
    parameter int NUM_BUCKETS = 32,
    parameter int NUM_SLOTS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_lifetime,
    input  logic        i_repeat_req,
    input  logic [3:0]  i_queue_id,
    input  logic [31:0] i_handler_tag,
    input  logic [31:0] i_arg_tag,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_fired_queue,
    output logic [31:0] o_fired_handler,
    output logic [31:0] o_fired_arg,
    output logic [5:0]  o_removed_count,
    output logic        o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lbtb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    lbtb_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .NUM_SLOTS   (NUM_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_func          (i_func),
        .i_lifetime      (i_lifetime),
        .i_repeat_req    (i_repeat_req),
        .i_queue_id      (i_queue_id),
        .i_handler_tag   (i_handler_tag),
        .i_arg_tag       (i_arg_tag),
        .o_stat          (w_stat),
        .o_strobe        (o_strobe),
        .o_kind          (o_kind),
        .o_fired_queue   (o_fired_queue),
        .o_fired_handler (o_fired_handler),
        .o_fired_arg     (o_fired_arg),
        .o_removed_count (o_removed_count),
        .o_last          (o_last)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Lifetime bucket timer bank testbench
// Drives add, delete, tick and unused-code commands from a queue, predicts the results
// with a behavioral timer bank, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb_top
    import lbtb_pkg::*;
();

    localparam int NB = 32;
    localparam int NS = 32;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        t_func       func;
        logic [15:0] lifetime;
        logic        rep;
        logic [3:0]  queue;
        logic [31:0] handler;
        logic [31:0] arg;
    } t_cmd_item;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  queue;
        logic [31:0] handler;
        logic [31:0] arg;
        logic [5:0]  removed;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [15:0] i_lifetime;
    logic        i_repeat_req;
    logic [3:0]  i_queue_id;
    logic [31:0] i_handler_tag;
    logic [31:0] i_arg_tag;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic [3:0]  o_fired_queue;
    logic [31:0] o_fired_handler;
    logic [31:0] o_fired_arg;
    logic [5:0]  o_removed_count;
    logic        o_last;

    lifetime_bucket_timer_bank_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_lifetime(i_lifetime), .i_repeat_req(i_repeat_req),
        .i_queue_id(i_queue_id), .i_handler_tag(i_handler_tag),
        .i_arg_tag(i_arg_tag), .o_strobe(o_strobe), .o_kind(o_kind),
        .o_fired_queue(o_fired_queue), .o_fired_handler(o_fired_handler),
        .o_fired_arg(o_fired_arg), .o_removed_count(o_removed_count),
        .o_last(o_last)
    );

    // timer bank state
    logic        tm_valid [NS];
    logic [4:0]  tm_bucket [NS];
    logic        tm_rep [NS];
    logic [3:0]  tm_queue [NS];
    logic [31:0] tm_handler [NS];
    logic [31:0] tm_arg [NS];
    logic [31:0] tm_expiry [NS];
    logic [15:0] tm_stamp [NS];
    logic [15:0] bk_life [NB];
    logic [5:0]  bk_count [NB];
    logic [31:0] now_sec;
    logic [15:0] stamp_cnt;

    t_cmd_item pending_cmds[$];
    t_result   expected_results[$];
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    bit        stim_done = 0;
    bit        finishing = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic t_result mk(t_kind k, logic [5:0] rm = 6'd0, logic l = 1'b1);
        t_result r;
        r = '{kind: k, queue: 4'd0, handler: 32'd0, arg: 32'd0, removed: rm, last: l};
        return r;
    endfunction

    function automatic int find_bucket(logic [15:0] lt);
        for (int b = 0; b < NB; b++)
            if (bk_life[b] == lt) return b;
        return -1;
    endfunction

    function automatic bit slot_hit(int s, int b, t_cmd_item c, logic rep);
        return tm_valid[s] && tm_bucket[s] == b[4:0] && tm_rep[s] == rep &&
               tm_queue[s] == c.queue && tm_handler[s] == c.handler && tm_arg[s] == c.arg;
    endfunction

    task automatic predict_timer_bank(t_cmd_item c);
        int b, s, n, best;
        bit claim;
        bit cand [NS];
        logic [15:0] snap;
        logic [5:0]  removed;
        logic [31:0] ax, ay;
        t_result r;
        claim = 0;
        case (c.func)
            F_ADD: begin
                b = find_bucket(c.lifetime);
                if (c.rep && b >= 0)
                    for (s = 0; s < NS; s++)
                        if (slot_hit(s, b, c, 1'b1)) begin
                            expected_results.push_back(mk(K_PRESENT));
                            return;
                        end
                if (b < 0) begin
                    for (b = 0; b < NB; b++)
                        if (bk_count[b] == 0) break;
                    if (b >= NB) begin
                        expected_results.push_back(mk(K_NO_BUCKET));
                        return;
                    end
                    claim = 1;
                end
                for (s = 0; s < NS; s++)
                    if (!tm_valid[s]) break;
                if (s >= NS) begin
                    expected_results.push_back(mk(K_NO_SLOT));
                    return;
                end
                if (claim) bk_life[b] = c.lifetime;
                tm_valid[s] = 1;
                tm_bucket[s] = b[4:0];
                tm_rep[s] = c.rep;
                tm_queue[s] = c.queue;
                tm_handler[s] = c.handler;
                tm_arg[s] = c.arg;
                tm_expiry[s] = now_sec + {16'd0, c.lifetime};
                tm_stamp[s] = stamp_cnt;
                stamp_cnt++;
                bk_count[b]++;
                expected_results.push_back(mk(K_ADDED));
            end
            F_DEL: begin
                removed = 0;
                b = find_bucket(c.lifetime);
                if (b >= 0)
                    for (s = 0; s < NS; s++)
                        if (slot_hit(s, b, c, c.rep)) begin
                            tm_valid[s] = 0;
                            if (bk_count[b] > 0) bk_count[b]--;
                            removed++;
                        end
                expected_results.push_back(mk(K_DELETED, removed));
            end
            F_TICK: begin
                n = 0;
                now_sec++;
                snap = stamp_cnt;
                for (s = 0; s < NS; s++)
                    cand[s] = tm_valid[s] && !((now_sec - tm_expiry[s]) >> 31);
                for (b = 0; b < NB && n < MAX_FIRE; b++) begin
                    while (n < MAX_FIRE) begin
                        best = -1;
                        for (s = 0; s < NS; s++)
                            if (cand[s] && tm_bucket[s] == b[4:0]) begin
                                if (best < 0) best = s;
                                else begin
                                    ax = now_sec - tm_expiry[s];
                                    ay = now_sec - tm_expiry[best];
                                    if (ax > ay || (ax == ay && 16'(snap - tm_stamp[s]) >
                                                    16'(snap - tm_stamp[best])))
                                        best = s;
                                end
                            end
                        if (best < 0) break;
                        cand[best] = 0;
                        r = '{kind: K_FIRED, queue: tm_queue[best], handler: tm_handler[best],
                              arg: tm_arg[best], removed: 6'd0, last: 1'b0};
                        expected_results.push_back(r);
                        n++;
                        if (tm_rep[best]) begin
                            tm_expiry[best] = now_sec + {16'd0, bk_life[b]};
                            tm_stamp[best] = stamp_cnt;
                            stamp_cnt++;
                        end else begin
                            tm_valid[best] = 0;
                            if (bk_count[b] > 0) bk_count[b]--;
                        end
                    end
                end
                if (n == 0) expected_results.push_back(mk(K_NONE_EXP));
                else expected_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) predict_timer_bank({i_func, i_lifetime, i_repeat_req, i_queue_id,
                                           i_handler_tag, i_arg_tag});
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_cmd_item c;
                c = pending_cmds.pop_front();
                start <= 1'b1;
                i_func <= c.func;
                i_lifetime <= c.lifetime;
                i_repeat_req <= c.rep;
                i_queue_id <= c.queue;
                i_handler_tag <= c.handler;
                i_arg_tag <= c.arg;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer kind", 32'(o_kind), 32'd0);
            end else begin
                t_result e;
                e = expected_results.pop_front();
                if (o_kind != e.kind) report_mismatch("kind", 32'(o_kind), 32'(e.kind));
                if (o_fired_queue != e.queue)
                    report_mismatch("queue", 32'(o_fired_queue), 32'(e.queue));
                if (o_fired_handler != e.handler)
                    report_mismatch("handler", o_fired_handler, e.handler);
                if (o_fired_arg != e.arg) report_mismatch("arg", o_fired_arg, e.arg);
                if (o_removed_count != e.removed)
                    report_mismatch("removed", 32'(o_removed_count), 32'(e.removed));
                if (o_last != e.last) report_mismatch("last", 32'(o_last), 32'(e.last));
            end
        end
        if (cycles > LIMIT) begin
            $display("** lifetime_bucket_timer_bank_top: FAILED **");
            $finish;
        end
    end

    function automatic t_cmd_item rand_cmd(t_func f, logic [15:0] lt);
        t_cmd_item c;
        c.func = f;
        c.lifetime = lt;
        c.rep = 1'($urandom_range(1));
        c.queue = 4'($urandom_range(15));
        c.handler = $urandom_range(3);
        c.arg = $urandom_range(1);
        return c;
    endfunction

    function automatic logic [31:0] ms_rand();
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_life();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1: return 16'(ms_rand());
            2: return 16'd0;
            default: return 16'($urandom_range(6));
        endcase
    endfunction

    initial begin
        t_cmd_item c;
        for (int s = 0; s < NS; s++) tm_valid[s] = 0;
        for (int b = 0; b < NB; b++) begin
            bk_life[b] = 0;
            bk_count[b] = 0;
        end
        now_sec = 0;
        stamp_cnt = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = F_NONE;
        i_lifetime = 0;
        i_repeat_req = 0;
        i_queue_id = 0;
        i_handler_tag = 0;
        i_arg_tag = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, deletes, zero lifetime, unused code
        c = '{F_TICK, 16'd0, 1'b0, 4'd0, 32'd0, 32'd0};
        pending_cmds.push_back(c);
        c = '{F_ADD, 16'd0, 1'b1, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        pending_cmds.push_back(c);
        pending_cmds.push_back(c);
        c = '{F_ADD, 16'hFFFF, 1'b0, 4'd0, 32'd0, 32'd0};
        pending_cmds.push_back(c);
        c = '{F_ADD, 16'd1, 1'b0, 4'h5, 32'hA5A5A5A5, 32'h5A5A5A5A};
        pending_cmds.push_back(c);
        pending_cmds.push_back(c);
        c = '{F_NONE, 16'hFFFF, 1'b1, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        pending_cmds.push_back(c);
        c = '{F_TICK, 16'd0, 1'b0, 4'd0, 32'd0, 32'd0};
        pending_cmds.push_back(c);
        pending_cmds.push_back(c);
        c = '{F_DEL, 16'd0, 1'b1, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        pending_cmds.push_back(c);
        c = '{F_DEL, 16'd77, 1'b0, 4'd0, 32'd0, 32'd0};
        pending_cmds.push_back(c);
        c = '{F_DEL, 16'hFFFF, 1'b0, 4'd0, 32'd0, 32'd0};
        pending_cmds.push_back(c);
        // fill slots then buckets
        for (int k = 0; k < 34; k++) begin
            c = '{F_ADD, 16'(k % 3), 1'b0, 4'(k), 32'(k), 32'd1};
            pending_cmds.push_back(c);
        end
        c = '{F_TICK, 16'd0, 1'b0, 4'd0, 32'd0, 32'd0};
        repeat (3) pending_cmds.push_back(c);
        for (int k = 0; k < 34; k++) begin
            c = '{F_ADD, 16'(100 + k), 1'b1, 4'd3, 32'(k), 32'd2};
            pending_cmds.push_back(c);
        end
        c = '{F_TICK, 16'd0, 1'b0, 4'd0, 32'd0, 32'd0};
        pending_cmds.push_back(c);
        for (int k = 0; k < 32; k++) begin
            c = '{F_DEL, 16'(100 + k), 1'b1, 4'd3, 32'(k), 32'd2};
            pending_cmds.push_back(c);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 86 : (ph == 3) ? 23 : 0;
            for (int k = 0; k < 34; k++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: c = rand_cmd(F_ADD, pick_life());
                    4, 5: c = rand_cmd(F_DEL, pick_life());
                    6: begin
                        c = rand_cmd(F_NONE, 16'(ms_rand()));
                        c.handler = ms_rand();
                        c.arg = ms_rand();
                    end
                    default: c = rand_cmd(F_TICK, 16'(ms_rand()));
                endcase
                pending_cmds.push_back(c);
            end
            wait (pending_cmds.size() == 0);
        end
        while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("** lifetime_bucket_timer_bank_top: PASSED **");
        else
            $display("** lifetime_bucket_timer_bank_top: FAILED **");
        $finish;
    end
endmodule
